>>> design/bhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhs_pkg;

  localparam int unsigned OpcodeBits = 2;
  localparam int unsigned KeyPortBits = 16;

  typedef enum logic [OpcodeBits-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // Broadcast controls from the top level to every cell of the row.
  typedef struct packed {
    logic fill;   // push into a stack that is not full
    logic shift;  // push into a full stack: move every entry down one slot
    logic pop;    // remove the top entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/bhs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bhs_req_if;
  import bhs_pkg::*;

  logic                   valid;
  logic                   ready;
  opcode_t                opcode;
  logic [KeyPortBits-1:0] key;
  logic                   is_dynamic;

  modport source (output valid, output opcode, output key, output is_dynamic, input ready);
  modport sink (input valid, input opcode, input key, input is_dynamic, output ready);
endinterface

`default_nettype wire

>>> design/bhs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bhs_rsp_if;
  import bhs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KeyPortBits-1:0] popped_key;
  logic                   popped_valid;
  logic                   found;
  logic                   dropped_oldest;
  logic                   stack_empty;

  modport source (
    output valid, output popped_key, output popped_valid, output found,
    output dropped_oldest, output stack_empty, input ready
  );
  modport sink (
    input valid, input popped_key, input popped_valid, input found,
    input dropped_oldest, input stack_empty, output ready
  );
endinterface

`default_nettype wire

>>> design/bounded_history_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Payload                                                | Handshake
// in_if    | sink      | opcode, key, is_dynamic                                | valid/ready
// out_if   | source    | popped_key, popped_valid, found, dropped_oldest,       | valid/ready
//          |           | stack_empty                                            |
//
// One request per cycle: each accepted request is resolved against the row of cells in
// the cycle it is accepted; its result is captured in the output register at the accepting
// edge and offered on out_if from the next cycle.
// The rate is set by the output register: a new request is taken whenever that register
// is empty or is being drained in the same cycle.
// Reset (rst_n, synchronous, active low) empties the stack and the output register at the
// first rising edge with rst_n low; in_if.ready stays low while rst_n is low.
// A stall on out_if holds the result and blocks in_if until the result is taken.

module bounded_history_stack_top #(
  parameter int unsigned STACK_DEPTH = 8,
  parameter int unsigned KEY_BITS    = 16
) (
  input wire       clk,
  input wire       rst_n,
  bhs_req_if.sink  in_if,
  bhs_rsp_if.source out_if
);
  import bhs_pkg::*;

  // Only the low KEY_BITS bits of a key take part; the port is fixed at 16 bits.
  localparam int unsigned KW = (KEY_BITS < KeyPortBits) ? KEY_BITS : KeyPortBits;

  logic                   accept;
  logic [KW-1:0]          req_key;
  logic                   key_zero;
  logic                   is_push;
  logic                   is_pop;
  logic                   is_query;
  logic                   full;
  logic                   empty;
  logic                   dup;
  logic                   do_push;
  logic [KW-1:0]          pop_key;
  cell_ctrl_t             ctrl;

  logic [KW-1:0]          cell_key   [STACK_DEPTH];
  logic [KW-1:0]          cell_top   [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_valid;
  logic [STACK_DEPTH-1:0] cell_valid_nxt;
  logic [STACK_DEPTH-1:0] cell_match;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [KeyPortBits-1:0] popped_key_r;
  logic                   popped_valid_r;
  logic                   found_r;
  logic                   dropped_r;
  logic                   empty_r;

  // Take a request whenever the output register is free or draining; hold off in reset.
  assign in_if.ready = rst_n && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  assign req_key  = in_if.key[KW-1:0];
  assign key_zero = (req_key == '0);
  assign is_push  = (in_if.opcode == OP_PUSH);
  assign is_pop   = (in_if.opcode == OP_POP);
  assign is_query = (in_if.opcode == OP_QUERY);

  // Live entries fill the low slots, so the valid bits form a thermometer.
  assign full  = cell_valid[STACK_DEPTH-1];
  assign empty = !cell_valid[0];
  assign dup   = |cell_match;

  // Drop pushes of key zero and dynamic pushes of a key already held.
  assign do_push = is_push && !key_zero && !(in_if.is_dynamic && dup);

  assign ctrl.fill  = accept && do_push && !full;
  assign ctrl.shift = accept && do_push && full;
  assign ctrl.pop   = accept && is_pop && !empty;

  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      // Neighbor above hands its entry down on a shift; the last cell gets the new key.
      logic [KW-1:0] above_key;
      logic          above_valid;
      logic          below_valid;

      if (g == STACK_DEPTH - 1) begin : g_last
        assign above_key   = req_key;
        assign above_valid = 1'b0;
      end else begin : g_mid
        assign above_key   = cell_key[g+1];
        assign above_valid = cell_valid[g+1];
      end

      if (g == 0) begin : g_first
        assign below_valid = 1'b1;
      end else begin : g_upper
        assign below_valid = cell_valid[g-1];
      end

      bhs_cell #(
        .KW (KW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_key     (req_key),
        .above_key   (above_key),
        .above_valid (above_valid),
        .below_valid (below_valid),
        .key         (cell_key[g]),
        .valid       (cell_valid[g]),
        .valid_nxt   (cell_valid_nxt[g]),
        .match       (cell_match[g]),
        .top_key     (cell_top[g])
      );
    end
  endgenerate

  // At most one cell is on top (none when the stack is empty), so an OR over the row picks its key.
  always_comb begin
    pop_key = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      pop_key = pop_key | cell_top[i];
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_key_r   <= (is_pop && !empty) ? KeyPortBits'(pop_key) : '0;
      popped_valid_r <= is_pop && !empty;
      // An empty slot counts as holding key zero.
      found_r        <= is_query && (key_zero ? !full : dup);
      dropped_r      <= do_push && full;
      empty_r        <= !cell_valid_nxt[0];
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.popped_key     = popped_key_r;
  assign out_if.popped_valid   = popped_valid_r;
  assign out_if.found          = found_r;
  assign out_if.dropped_oldest = dropped_r;
  assign out_if.stack_empty    = empty_r;

endmodule

`default_nettype wire

>>> design/bhs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bhs_cell #(
  parameter int unsigned KW = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire bhs_pkg::cell_ctrl_t  ctrl,
  input  wire  [KW-1:0]             new_key,
  input  wire  [KW-1:0]             above_key,
  input  wire                       above_valid,
  input  wire                       below_valid,
  output logic [KW-1:0]             key,
  output logic                      valid,
  output logic                      valid_nxt,
  output logic                      match,
  output logic [KW-1:0]             top_key
);
  import bhs_pkg::*;

  logic [KW-1:0] key_r, key_nxt;
  logic          valid_r;
  logic          is_top;

  assign is_top = valid_r && !above_valid;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      // take the neighbor's entry; the last cell sees the new key there
      key_nxt = above_key;
    end else if (ctrl.fill && !valid_r && below_valid) begin
      key_nxt   = new_key;
      valid_nxt = 1'b1;
    end else if (ctrl.pop && is_top) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign key     = key_r;
  assign valid   = valid_r;
  assign match   = valid_r && (key_r == new_key);
  assign top_key = is_top ? key_r : '0;

endmodule

`default_nettype wire
